@@ src/fccw_pkg.sv @@
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types and constants of the FAT32 cluster chain walker: operation
// codes, entry marker values, register map and controller/datapath links.
// ----------------------------------------------------------------------------
package fccw_pkg;

  localparam int TABLE_ENTRIES_DEF = 65536;
  localparam int CFG_AW            = 3;
  localparam int CFG_DW            = 32;
  localparam int TB_W              = 19;
  localparam int LEN_W             = 17;

  localparam logic [TB_W-1:0] TABLE_BYTES_RESET = 19'd262144;

  localparam logic [31:0] ENTRY_MASK   = 32'h0FFF_FFFF;
  localparam logic [31:0] END_FIRST    = 32'h0FFF_FFF8;
  localparam logic [31:0] BAD_MARK     = 32'h0FFF_FFF7;
  localparam logic [31:0] OUT_OF_RANGE = 32'hFFFF_FFFF;

  // Register word index, taken from paddr[2].
  localparam logic REG_TABLE_BYTES = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_WALK    = 2'd1,
    OP_INSPECT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;  // item taken this cycle
    logic step;    // table data for the current cluster is on the read port
  } fccw_cmd_t;

  typedef struct packed {
    logic needs_read;  // incoming item reads the table
    logic done;        // current read finishes the item
  } fccw_status_t;

endpackage

@@ src/fat32_cluster_chain_walker.sv @@
// ----------------------------------------------------------------------------
// fat32_cluster_chain_walker
// Holds a FAT32 allocation table and answers load, chain-walk and inspect
// items, one result per item.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  ---------------------------------
//  input     start & !busy                   in_op, in_cluster, in_entry_value
//  result    out_valid (one-cycle strobe)    out_chain_length .. out_is_last
//  config    psel & penable & pwrite         paddr, pwdata (prdata on reads)
//
// Cycles: a load or an unknown op returns its strobe in the cycle after the
// transaction, and a new item may enter every cycle while busy is low. An
// inspect reads one entry; a walk reads at most TABLE_ENTRIES entries. Each
// table read goes through the registered RAM read port, which paces walks.
// Reset (rst_n low, synchronous) idles the controller and restores
// table_bytes; the table contents stay undefined until loaded.
// The result channel has no back-pressure; busy holds off items only during
// table reads.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_walker #(
  parameter int TABLE_ENTRIES = fccw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [31:0]                 in_cluster,
  input  logic [31:0]                 in_entry_value,
  // result channel
  output logic                        out_valid,
  output logic [fccw_pkg::LEN_W-1:0]  out_chain_length,
  output logic                        out_cycle_seen,
  output logic [31:0]                 out_next_cluster,
  output logic                        out_number_valid,
  output logic                        out_is_free,
  output logic                        out_is_bad,
  output logic                        out_is_last,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fccw_pkg::CFG_AW-1:0] paddr,
  input  logic [fccw_pkg::CFG_DW-1:0] pwdata,
  output logic [fccw_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import fccw_pkg::*;

  fccw_cmd_t    cmd;
  fccw_status_t status;

  logic [TB_W-1:0] table_bytes_r, table_bytes_nxt;
  logic            cfg_wr;

  // Register file: one word, table_bytes, at byte address 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    table_bytes_nxt = table_bytes_r;
    if (cfg_wr && (paddr[2] == REG_TABLE_BYTES)) begin
      table_bytes_nxt = pwdata[TB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_bytes_r <= TABLE_BYTES_RESET;
    end else begin
      table_bytes_r <= table_bytes_nxt;
    end
  end

  // Read back the addressed word; beyond the map read zero.
  assign prdata = (paddr[2] == REG_TABLE_BYTES) ?
                  {{(CFG_DW-TB_W){1'b0}}, table_bytes_r} : '0;

  // Controller: accept, walk sequencing, result strobe.
  fccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: table RAM, link follow, chain counter, result registers.
  fccw_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .in_op            (in_op),
    .in_cluster       (in_cluster),
    .in_entry_value   (in_entry_value),
    .table_bytes      (table_bytes_r),
    .cmd              (cmd),
    .status           (status),
    .out_chain_length (out_chain_length),
    .out_cycle_seen   (out_cycle_seen),
    .out_next_cluster (out_next_cluster),
    .out_number_valid (out_number_valid),
    .out_is_free      (out_is_free),
    .out_is_bad       (out_is_bad),
    .out_is_last      (out_is_last)
  );

  // A load transaction is answered in the very next cycle.
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_LOAD)) |=> out_valid)
    else $error("load item not answered in the next cycle");

  // A walk or inspect leaves the busy state only through a result strobe.
  a_busy_exit: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || out_valid))
    else $error("read sequence ended without a result");

  // Entry classes are mutually exclusive.
  a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_is_free, out_is_bad, out_is_last}))
    else $error("entry classified into more than one class");

  // A cycle flag comes only with a chain that was actually counted.
  a_cycle_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cycle_seen) |-> (out_chain_length != '0 || TABLE_ENTRIES > 65535))
    else $error("cycle flag raised on an empty chain");

endmodule

@@ src/fccw_ram.sv @@
// ----------------------------------------------------------------------------
// fccw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fccw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/fccw_ctrl.sv @@
// ----------------------------------------------------------------------------
// fccw_ctrl
// Controller: accepts items, sequences the table reads of a walk and raises
// the result strobe.
// ----------------------------------------------------------------------------
module fccw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output logic                  out_valid,
  output fccw_pkg::fccw_cmd_t    cmd,
  input  fccw_pkg::fccw_status_t status
);
  import fccw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r == ST_WALK);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_nxt = status.needs_read ? ST_WALK : ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (status.done) begin
          state_nxt = ST_DONE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.accept = accept;
  assign cmd.step   = (state_r == ST_WALK);
  assign out_valid  = (state_r == ST_DONE);

endmodule

@@ src/fccw_datapath.sv @@
// ----------------------------------------------------------------------------
// fccw_datapath
// Datapath: allocation table RAM, range check, link follow, chain counter
// and result registers.
// ----------------------------------------------------------------------------
module fccw_datapath #(
  parameter int TABLE_ENTRIES = fccw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic [1:0]                   in_op,
  input  logic [31:0]                  in_cluster,
  input  logic [31:0]                  in_entry_value,
  input  logic [fccw_pkg::TB_W-1:0]    table_bytes,
  input  fccw_pkg::fccw_cmd_t          cmd,
  output fccw_pkg::fccw_status_t       status,
  output logic [fccw_pkg::LEN_W-1:0]   out_chain_length,
  output logic                         out_cycle_seen,
  output logic [31:0]                  out_next_cluster,
  output logic                         out_number_valid,
  output logic                         out_is_free,
  output logic                         out_is_bad,
  output logic                         out_is_last
);
  import fccw_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = AW + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [31:0]      DEPTH_32  = 32'(TABLE_ENTRIES);

  function automatic logic in_range(input logic [31:0] c, input logic [TB_W-1:0] tb);
    logic ok;
    ok = (c >= 32'd2) && (c < DEPTH_32) && (c[31:17] == 15'd0) &&
         ({c[16:0], 2'b00} < tb);
    return ok;
  endfunction

  // Item context
  logic [1:0]       op_r;
  logic             inr_r;    // range flag of the cluster being read
  logic             lowok_r;  // start cluster below the end marker range
  logic             first_r;  // read data is the start cluster's entry
  logic [CNT_W-1:0] len_r;

  // Result registers
  logic [LEN_W-1:0] len_res_r;
  logic             cyc_res_r;
  logic [31:0]      raw_res_r;
  logic             val_res_r, free_res_r, bad_res_r, last_res_r;

  // RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // Step decode
  logic [31:0]      ent, m;
  logic             m_last;
  logic [CNT_W-1:0] len_eff;
  logic [CNT_W+LEN_W-1:0] len_ext;
  logic             walk_stop_free, walk_over, step_done, step_cont;
  logic             start_read;

  assign start_read = (in_op == OP_WALK) || (in_op == OP_INSPECT);

  assign ent     = inr_r ? ram_rdata : OUT_OF_RANGE;
  assign m       = ent & ENTRY_MASK;
  assign m_last  = (m >= END_FIRST);
  assign len_eff = first_r ? CNT_W'(1) : len_r;
  assign len_ext = {{LEN_W{1'b0}}, len_eff};

  assign walk_stop_free = first_r && ((m == 32'd0) || !lowok_r);
  assign walk_over      = (len_eff >= DEPTH_CNT);
  assign step_done = (op_r != OP_WALK) || walk_stop_free || m_last || walk_over;
  assign step_cont = cmd.step && !step_done;

  assign ram_we    = cmd.accept && (in_op == OP_LOAD) && (in_cluster < DEPTH_32);
  assign ram_re    = (cmd.accept && start_read) || step_cont;
  assign ram_raddr = cmd.accept ? in_cluster[AW-1:0] : m[AW-1:0];

  fccw_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_cluster[AW-1:0]),
    .wdata (in_entry_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      inr_r   <= in_range(in_cluster, table_bytes);
      lowok_r <= ((in_cluster & ENTRY_MASK) < END_FIRST);
      first_r <= 1'b1;
      len_r   <= '0;
    end else if (step_cont) begin
      inr_r   <= in_range(m, table_bytes);
      first_r <= 1'b0;
      len_r   <= len_eff + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !start_read) begin
      len_res_r  <= '0;
      cyc_res_r  <= 1'b0;
      raw_res_r  <= '0;
      val_res_r  <= 1'b0;
      free_res_r <= 1'b0;
      bad_res_r  <= 1'b0;
      last_res_r <= 1'b0;
    end else if (cmd.step && step_done) begin
      if (op_r == OP_INSPECT) begin
        len_res_r  <= '0;
        cyc_res_r  <= 1'b0;
        raw_res_r  <= ent;
        val_res_r  <= inr_r && lowok_r;
        free_res_r <= (m == 32'd0);
        bad_res_r  <= (m == BAD_MARK);
        last_res_r <= m_last;
      end else begin
        len_res_r  <= walk_stop_free ? '0 : len_ext[LEN_W-1:0];
        cyc_res_r  <= !walk_stop_free && !m_last && walk_over;
        raw_res_r  <= '0;
        val_res_r  <= 1'b0;
        free_res_r <= 1'b0;
        bad_res_r  <= 1'b0;
        last_res_r <= 1'b0;
      end
    end
  end

  assign status.needs_read = start_read;
  assign status.done       = step_done;

  assign out_chain_length = len_res_r;
  assign out_cycle_seen   = cyc_res_r;
  assign out_next_cluster = raw_res_r;
  assign out_number_valid = val_res_r;
  assign out_is_free      = free_res_r;
  assign out_is_bad       = bad_res_r;
  assign out_is_last      = last_res_r;

endmodule

@@ test/tb_fat32_cluster_chain_walker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat32_cluster_chain_walker
// Self-checking bench for the FAT32 cluster chain walker. Loads, chain walks,
// inspects and unknown ops go in through the start/busy port. Each one is
// scored against a cycle-free model of the allocation table. The table size
// register is written and read back over the APB-style port between phases.
// ----------------------------------------------------------------------------
module tb_fat32_cluster_chain_walker;
  import fccw_pkg::*;

  localparam int DEPTH     = TABLE_ENTRIES_DEF;
  // Longest walk that the random part lets through; longer ones become inspects.
  localparam int PROBE_CAP = 300;
  localparam logic [CFG_AW-1:0] TABLE_BYTES_ADDR = {REG_TABLE_BYTES, 2'b00};

  typedef struct packed {
    logic [LEN_W-1:0] chain_length;
    logic             cycle_seen;
    logic [31:0]      next_cluster;
    logic             number_valid;
    logic             is_free;
    logic             is_bad;
    logic             is_last;
  } answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the allocation table and of table_bytes,
  // the answer predictor, and the queue of answers still owed by the block.
  // --------------------------------------------------------------------------
  class chain_scoreboard;
    logic [31:0]     fat [DEPTH];
    bit              written [DEPTH];
    int unsigned     loaded [$];        // clusters that hold a known entry
    logic [TB_W-1:0] table_bytes;
    answer_t         pending_answers [$];
    int              errors;
    // Set by the last prediction: an unloaded entry was touched, or the walk
    // ran past the caller's cap.
    bit              blank_hit;
    logic [31:0]     blank_cl;
    bit              capped;

    function new();
      table_bytes = TABLE_BYTES_RESET;
      errors      = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function bit in_table(logic [31:0] c);
      return c >= 2 && c < DEPTH && {c[29:0], 2'b00} < 32'(table_bytes);
    endfunction

    // First cluster number that is out of range under the current size.
    function int unsigned range_limit();
      int unsigned lim;
      lim = (32'(table_bytes) + 3) / 4;
      return (lim > DEPTH) ? DEPTH : lim;
    endfunction

    function logic [31:0] fetch(logic [31:0] c);
      if (!in_table(c)) return OUT_OF_RANGE;
      if (!written[c[15:0]]) begin
        blank_hit = 1'b1;
        blank_cl  = c;
      end
      return fat[c[15:0]];
    endfunction

    function answer_t predict_answer(op_t op, logic [31:0] c, int cap);
      answer_t     a;
      logic [31:0] m;
      logic [31:0] cur;
      int          len;
      a         = '0;
      blank_hit = 1'b0;
      capped    = 1'b0;
      case (op)
        OP_WALK: begin
          m = fetch(c) & ENTRY_MASK;
          if (!blank_hit && m != 0 && (c & ENTRY_MASK) < END_FIRST) begin
            cur = c;
            len = 1;
            forever begin
              m = fetch(cur) & ENTRY_MASK;
              if (blank_hit || m >= END_FIRST) break;
              if (len >= DEPTH) begin
                a.cycle_seen = 1'b1;
                break;
              end
              if (len >= cap) begin
                capped = 1'b1;
                break;
              end
              len++;
              cur = m;
            end
            a.chain_length = LEN_W'(len);
          end
        end
        OP_INSPECT: begin
          a.next_cluster = fetch(c);
          m              = a.next_cluster & ENTRY_MASK;
          a.number_valid = in_table(c) && (c & ENTRY_MASK) < END_FIRST;
          a.is_free      = (m == 0);
          a.is_bad       = (m == BAD_MARK);
          a.is_last      = (m >= END_FIRST);
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_item(op_t op, logic [31:0] c, logic [31:0] v);
      pending_answers.insert(pending_answers.size(), predict_answer(op, c, DEPTH + 1));
      if (op == OP_LOAD && c < DEPTH) begin
        if (!written[c[15:0]]) loaded.insert(loaded.size(), c);
        written[c[15:0]] = 1'b1;
        fat[c[15:0]]     = v;
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        flag($sformatf("%s: expected 0x%08h, got 0x%08h", name, want, got));
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        flag("result strobe with no transaction pending");
        return;
      end
      want = pending_answers.pop_front();
      check_field("chain_length", 32'(want.chain_length), 32'(got.chain_length));
      check_field("cycle_seen", 32'(want.cycle_seen), 32'(got.cycle_seen));
      check_field("next_cluster", want.next_cluster, got.next_cluster);
      check_field("number_valid", 32'(want.number_valid), 32'(got.number_valid));
      check_field("is_free", 32'(want.is_free), 32'(got.is_free));
      check_field("is_bad", 32'(want.is_bad), 32'(got.is_bad));
      check_field("is_last", 32'(want.is_last), 32'(got.is_last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic [1:0]        in_op          = OP_NONE;
  logic [31:0]       in_cluster     = '0;
  logic [31:0]       in_entry_value = '0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [CFG_AW-1:0] paddr          = '0;
  logic [CFG_DW-1:0] pwdata         = '0;
  logic              busy;
  logic              out_valid;
  logic [LEN_W-1:0]  out_chain_length;
  logic              out_cycle_seen;
  logic [31:0]       out_next_cluster;
  logic              out_number_valid;
  logic              out_is_free;
  logic              out_is_bad;
  logic              out_is_last;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  chain_scoreboard sb;
  int              items_sent = 0;  // transactions that the block acts on

  fat32_cluster_chain_walker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_cluster       (in_cluster),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_chain_length (out_chain_length),
    .out_cycle_seen   (out_cycle_seen),
    .out_next_cluster (out_next_cluster),
    .out_number_valid (out_number_valid),
    .out_is_free      (out_is_free),
    .out_is_bad       (out_is_bad),
    .out_is_last      (out_is_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Score each result strobe at the edge that ends its cycle; the values read
  // here are the ones held before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_chain_length, out_cycle_seen, out_next_cluster,
                       out_number_valid, out_is_free, out_is_bad, out_is_last});
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task is entered and left right after a rising edge, so all
  // nonblocking updates land at the edge and are seen by the next one.
  // --------------------------------------------------------------------------

  // Present one transaction and hold it until the block takes it.
  task automatic drive_item(op_t op, logic [31:0] c, logic [31:0] v);
    start          <= 1'b1;
    in_op          <= op;
    in_cluster     <= c;
    in_entry_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, c, v);
    if (!(op == OP_NONE || (op == OP_LOAD && c >= DEPTH))) items_sent++;
  endtask

  // Drop start for a random number of cycles; pct is the idle chance per cycle.
  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
  endtask

  // Hold off until every owed answer has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Optionally write table_bytes, then read it back and compare.
  task automatic cfg_access(bit do_write, logic [TB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= do_write;
    paddr   <= TABLE_BYTES_ADDR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (do_write) begin
      sb.table_bytes = value;
      // back to setup for the read-back, keeping psel high
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    if (prdata !== CFG_DW'(sb.table_bytes))
      sb.flag($sformatf("table_bytes read-back: expected 0x%08h, got 0x%08h",
                        CFG_DW'(sb.table_bytes), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] end_marker();
    return {4'($urandom), 28'(END_FIRST) | 28'($urandom_range(7))};
  endfunction

  function automatic logic [31:0] pick_known();
    if (sb.loaded.size() == 0) return 32'd2;
    return sb.loaded[$urandom_range(sb.loaded.size() - 1)];
  endfunction

  // Send a walk or inspect, but never one that reads an unloaded entry: load
  // that entry with an end marker instead. Turn overlong walks into inspects.
  task automatic issue_read(op_t op, logic [31:0] c, int pct);
    void'(sb.predict_answer(op, c, PROBE_CAP));
    if (sb.blank_hit)
      drive_item(OP_LOAD, sb.blank_cl, end_marker());
    else if (sb.capped)
      drive_item(OP_INSPECT, c, $urandom);
    else
      drive_item(op, c, $urandom);
    sender_gap(pct);
  endtask

  // Lay down a chain of 1..10 links, usually closed by an end marker but now
  // and then by a bad or free entry, then walk it and maybe inspect a link.
  task automatic build_chain(int pct);
    int          n;
    int unsigned lim;
    logic [31:0] nodes [$];
    logic [31:0] v;
    lim = sb.range_limit();
    n   = $urandom_range(10, 1);
    repeat (n)
      nodes.insert(nodes.size(),
                   (lim > 2) ? $urandom_range(lim - 1, 2) : $urandom_range(1023, 0));
    foreach (nodes[i]) begin
      if (i < n - 1) begin
        v = {4'($urandom), 28'(nodes[i + 1])};
      end else begin
        case ($urandom_range(7))
          0:       v = {4'($urandom), 28'(BAD_MARK)};
          1:       v = {4'($urandom), 28'h0};
          default: v = end_marker();
        endcase
      end
      drive_item(OP_LOAD, nodes[i], v);
      sender_gap(pct);
    end
    issue_read(OP_WALK, nodes[0], pct);
    if ($urandom_range(1)) issue_read(OP_INSPECT, nodes[$urandom_range(n - 1)], pct);
  endtask

  // One random step: mostly chains, then walks and inspects of known and odd
  // clusters, stray loads (many outside the store) and unknown ops.
  task automatic random_item(int pct);
    int          r;
    int unsigned lim;
    logic [31:0] c;
    r   = $urandom_range(99);
    lim = sb.range_limit();
    if (r < 40) begin
      build_chain(pct);
    end else if (r < 58) begin
      issue_read(OP_WALK, pick_known(), pct);
    end else if (r < 66) begin
      issue_read(OP_WALK, $urandom, pct);
    end else if (r < 80) begin
      case ($urandom_range(3))
        0:       c = pick_known();
        1:       c = $urandom;
        2:       c = $urandom_range(1);
        default: c = lim - 1 + $urandom_range(1);  // straddle the range edge
      endcase
      issue_read(OP_INSPECT, c, pct);
    end else if (r < 94) begin
      c = $urandom_range(1) ? $urandom : $urandom_range(DEPTH - 1);
      drive_item(OP_LOAD, c, $urandom);
      sender_gap(pct);
    end else begin
      drive_item(OP_NONE, $urandom, $urandom);
      sender_gap(pct);
    end
  endtask

  task automatic run_slice(int n, int pct);
    int first;
    first = items_sent;
    while (items_sent - first < n) begin
      random_item(pct);
      if ($urandom_range(199) == 0) wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of table_bytes.
    cfg_access(1'b0, '0);

    // Directed: short chain with reserved upper bits on a link.
    drive_item(OP_LOAD, 32'd2, 32'h0000_0003);
    drive_item(OP_LOAD, 32'd3, 32'hF000_0004);
    drive_item(OP_LOAD, 32'd4, 32'h0FFF_FFF8);
    drive_item(OP_WALK, 32'd2, 32'h0);
    drive_item(OP_INSPECT, 32'd3, 32'hFFFF_FFFF);
    // Free start entry.
    drive_item(OP_LOAD, 32'd5, 32'h0);
    drive_item(OP_WALK, 32'd5, 32'h0);
    drive_item(OP_INSPECT, 32'd5, 32'h0);
    // Bad marker: inspect flags it, a walk steps through it.
    drive_item(OP_LOAD, 32'd6, 32'h0FFF_FFF7);
    drive_item(OP_INSPECT, 32'd6, 32'h0);
    drive_item(OP_WALK, 32'd6, 32'h0);
    // Start entry already holds the end marker.
    drive_item(OP_LOAD, 32'd7, 32'hFFFF_FFFF);
    drive_item(OP_WALK, 32'd7, 32'h0);
    // Start cluster number is itself in the end range.
    drive_item(OP_WALK, 32'h0FFF_FFF8, 32'h0);
    drive_item(OP_WALK, 32'hFFFF_FFFF, 32'h0);
    // Clusters 0 and 1 never name table data.
    drive_item(OP_INSPECT, 32'd0, 32'h0);
    drive_item(OP_INSPECT, 32'd1, 32'h0);
    // Top of the store, then just past it.
    drive_item(OP_LOAD, 32'(DEPTH - 1), 32'h0FFF_FFFF);
    drive_item(OP_INSPECT, 32'(DEPTH - 1), 32'h0);
    drive_item(OP_WALK, 32'(DEPTH - 1), 32'h0);
    drive_item(OP_LOAD, 32'(DEPTH), 32'h1234_5678);
    drive_item(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(OP_INSPECT, 32'(DEPTH), 32'h0);
    drive_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Self-linked entry: walk runs to full depth and raises the cycle flag.
    drive_item(OP_LOAD, 32'd8, 32'd8);
    drive_item(OP_WALK, 32'd8, 32'h0);
    wait_drained();

    // Tiny table (clusters 2..9): walk off the end, and the loop once more.
    cfg_access(1'b1, 19'd40);
    drive_item(OP_LOAD, 32'd9, 32'h0000_000A);
    drive_item(OP_WALK, 32'd9, 32'h0);
    drive_item(OP_INSPECT, 32'd10, 32'h0);
    drive_item(OP_WALK, 32'd8, 32'h0);
    wait_drained();

    // Random phases: light sender idling, heavy idling, then none, each
    // under a different table size, the extremes among them.
    cfg_access(1'b1, 19'h7FFFF);
    run_slice(400, 12);
    wait_drained();
    cfg_access(1'b1, 19'd1024);
    run_slice(300, 87);
    wait_drained();
    cfg_access(1'b1, 19'd0);
    run_slice(100, 87);
    wait_drained();
    cfg_access(1'b1, 19'd9);
    run_slice(100, 0);
    wait_drained();
    cfg_access(1'b1, TABLE_BYTES_RESET);
    run_slice(250, 0);
    wait_drained();

    // Give a stray strobe time to show up.
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this sequence.
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/fccw_pkg.sv
src/fccw_ram.sv
src/fccw_ctrl.sv
src/fccw_datapath.sv
src/fat32_cluster_chain_walker.sv
test/tb_fat32_cluster_chain_walker.sv
